// File: design/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

    // Field and code geometry.
    localparam int SYM_W        = 8;
    localparam int PARITY_COUNT = 16;

    // Port widths fixed by the stream format.
    localparam int SYMBOL_IN_W = 8;
    localparam int INDEX_OUT_W = 4;
    localparam int VALUE_OUT_W = 8;
    localparam int POLY_W      = 8;

    localparam logic [POLY_W-1:0] POLY_RESET = POLY_W'(29);

    // Counter widths.
    localparam int IDX_W  = (PARITY_COUNT > 1) ? $clog2(PARITY_COUNT) : 1;
    localparam int LEFT_W = $clog2(PARITY_COUNT + 1);

    typedef logic [SYM_W-1:0] t_sym;

    // Control that every cell in the row receives in the same cycle.
    typedef struct packed {
        logic advance;   // a symbol beat is taken
        logic close;     // that beat ends the codeword
        logic shift;     // the shadow row moves one cell towards the output
        logic restart;   // new field polynomial: abandon the word in progress
    } t_cell_ctrl;

    // Multiply by alpha, reducing modulo the field polynomial.
    function automatic t_sym gf_xtime(input t_sym a, input t_sym poly);
        t_sym r;
        r = {a[SYM_W-2:0], 1'b0};
        if (a[SYM_W-1]) begin
            r = r ^ poly;
        end
        return r;
    endfunction

    // Shift-and-add field multiplication, most significant bit of b first.
    function automatic t_sym gf_mul(input t_sym a, input t_sym b, input t_sym poly);
        t_sym r;
        r = '0;
        for (int k = SYM_W - 1; k >= 0; k--) begin
            r = gf_xtime(r, poly);
            if (b[k]) begin
                r = r ^ a;
            end
        end
        return r;
    endfunction

endpackage

// File: design/rsc_cell.sv
`timescale 1ns / 1ps

module rsc_cell
    import rsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sym       i_poly,
    input  t_cell_ctrl i_ctrl,
    input  t_sym       i_symbol,
    input  t_sym       i_step,
    output t_sym       o_step,
    input  t_sym       i_shadow,
    output t_sym       o_shadow
);

    t_sym r_sum;
    t_sym r_pow;
    t_sym r_step;
    t_sym r_shadow;
    t_sym n_sum;
    t_sym n_pow;
    t_sym n_step;
    t_sym n_shadow;
    t_sym sum_upd;
    t_sym pow_upd;

    assign sum_upd = r_sum ^ gf_mul(i_symbol, r_pow, i_poly);
    assign pow_upd = gf_mul(r_pow, r_step, i_poly);

    // The step factor ripples down the row: this cell holds alpha times its
    // neighbour's factor, so the row settles one cell per cycle.
    assign n_step = gf_xtime(i_step, i_poly);

    always_comb begin
        n_sum    = r_sum;
        n_pow    = r_pow;
        n_shadow = r_shadow;
        if (i_ctrl.restart) begin
            n_sum = '0;
            n_pow = SYM_W'(1);
        end else if (i_ctrl.advance) begin
            if (i_ctrl.close) begin
                n_sum = '0;
                n_pow = SYM_W'(1);
            end else begin
                n_sum = sum_upd;
                n_pow = pow_upd;
            end
        end
        if (i_ctrl.advance && i_ctrl.close) begin
            n_shadow = sum_upd;
        end else if (i_ctrl.shift) begin
            n_shadow = i_shadow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_pow <= SYM_W'(1);
        end else begin
            r_sum <= n_sum;
            r_pow <= n_pow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_shadow <= n_shadow;
    end

    assign o_step   = r_step;
    assign o_shadow = r_shadow;

endmodule

// File: design/rs_syndrome_calculator_core.sv
`timescale 1ns / 1ps
// Channel     Dir  Handshake                  Contents
// s_axis      in   tvalid / tready            tdata: symbol; tlast: last_symbol
// m_axis      out  tvalid / tready            tdata: syndrome_value;
//                                             tuser: syndrome_index; tlast: last_syndrome
// cfg         in   we (no wait)               wdata: field_polynomial
//
// Every cell updates its syndrome in the cycle a symbol beat is taken, so a symbol
// is accepted in every cycle the input is not stalled. A closing beat copies all
// sums into a shadow row that drains one syndrome per cycle while m_axis is ready;
// a further closing beat waits until the row is empty or hands over its final
// syndrome in that cycle. After reset and each polynomial write the input stalls
// while the step factors ripple down the row; configuration writes are taken at any time.

module rs_syndrome_calculator_core
    import rsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [POLY_W-1:0]      i_cfg_wdata,      // field_polynomial
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SYMBOL_IN_W-1:0] i_s_axis_tdata,   // [7:0] symbol
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [VALUE_OUT_W-1:0] o_m_axis_tdata,   // [7:0] syndrome_value
    output logic [INDEX_OUT_W-1:0] o_m_axis_tuser,   // [3:0] syndrome_index
    output logic                   o_m_axis_tlast
);

    logic [POLY_W-1:0] r_poly;
    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] n_left;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [LEFT_W-1:0] r_settle;
    logic [LEFT_W-1:0] n_settle;

    logic       in_take;
    logic       out_take;
    logic       room;
    t_sym       poly;
    t_cell_ctrl ctrl;
    t_sym       step_chain   [PARITY_COUNT+1];
    t_sym       shadow_chain [PARITY_COUNT+1];

    assign poly     = r_poly[SYM_W-1:0];
    assign out_take = o_m_axis_tvalid && i_m_axis_tready;

    // A closing beat may load the shadow row once it is empty or is handing
    // over its final syndrome in this same cycle.
    assign room = (r_left == '0) || ((r_left == LEFT_W'(1)) && i_m_axis_tready);
    assign o_s_axis_tready = (r_settle == '0) && (!i_s_axis_tlast || room);
    assign in_take = i_s_axis_tvalid && o_s_axis_tready;

    assign ctrl.advance = in_take;
    assign ctrl.close   = i_s_axis_tlast;
    assign ctrl.shift   = out_take;
    assign ctrl.restart = i_cfg_we;

    assign step_chain[0]              = SYM_W'(1);
    assign shadow_chain[PARITY_COUNT] = '0;

    for (genvar j = 0; j < PARITY_COUNT; j++) begin : g_cell
        rsc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_poly   (poly),
            .i_ctrl   (ctrl),
            .i_symbol (i_s_axis_tdata[SYM_W-1:0]),
            .i_step   (step_chain[j]),
            .o_step   (step_chain[j+1]),
            .i_shadow (shadow_chain[j+1]),
            .o_shadow (shadow_chain[j])
        );
    end

    always_comb begin
        n_left   = r_left;
        n_idx    = r_idx;
        n_settle = r_settle;
        if (in_take && i_s_axis_tlast) begin
            n_left = LEFT_W'(PARITY_COUNT);
            n_idx  = '0;
        end else if (out_take) begin
            n_left = r_left - LEFT_W'(1);
            n_idx  = r_idx + IDX_W'(1);
        end
        if (i_cfg_we) begin
            n_settle = LEFT_W'(PARITY_COUNT);
        end else if (r_settle != '0) begin
            n_settle = r_settle - LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly   <= POLY_RESET;
            r_left   <= '0;
            r_idx    <= '0;
            r_settle <= LEFT_W'(PARITY_COUNT);
        end else begin
            if (i_cfg_we) begin
                r_poly <= i_cfg_wdata;
            end
            r_left   <= n_left;
            r_idx    <= n_idx;
            r_settle <= n_settle;
        end
    end

    assign o_m_axis_tvalid = (r_left != '0);
    assign o_m_axis_tdata  = VALUE_OUT_W'(shadow_chain[0]);
    assign o_m_axis_tuser  = INDEX_OUT_W'(r_idx);
    assign o_m_axis_tlast  = (r_left == LEFT_W'(1));

endmodule
